@@ rtl/sgnt_pkg.sv @@
// shared types, constants and helpers of the stereo gated nearest tracker
package sgnt_pkg;

    // coordinate width kept inside the tracker (low bits of each field)
    localparam int COORD_W = 16;
    // width of every coordinate field on the channels
    localparam int FIELD_W = 16;
    // squared distance: two squares summed
    localparam int SQ_W    = 2 * COORD_W + 1;
    // squared gate radius
    localparam int GSQ_W   = 2 * FIELD_W;
    // common width for the gate compare
    localparam int GCMP_W  = (SQ_W > GSQ_W) ? SQ_W : GSQ_W;
    // common width for the disparity compare
    localparam int DISP_W  = (COORD_W > FIELD_W) ? COORD_W : FIELD_W;
    localparam int CNT_W   = 8;
    localparam int CFG_IDX_W = 2;

    // register reset values
    localparam logic [FIELD_W-1:0] GATE_RST     = FIELD_W'(480);
    localparam logic [GSQ_W-1:0]   GATE_SQ_RST  = GSQ_W'(480 * 480);
    localparam logic [FIELD_W-1:0] MIN_DISP_RST = FIELD_W'(1600);
    localparam logic [FIELD_W-1:0] MAX_DISP_RST = FIELD_W'(14400);
    localparam logic [CNT_W-1:0]   LIMIT_RST    = CNT_W'(30);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd3;

    // request function codes
    typedef enum logic [1:0] {
        FUNC_POINT = 2'd0,
        FUNC_EOF   = 2'd1,
        FUNC_SET   = 2'd2
    } t_func;

    // result status codes
    typedef enum logic [1:0] {
        ST_ACCEPT = 2'd0,
        ST_MISS   = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [1:0]         func;
        logic               side;
        logic [FIELD_W-1:0] point_x;
        logic [FIELD_W-1:0] point_y;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               is_lost;
        logic [CNT_W-1:0]   miss_count;
        logic [FIELD_W-1:0] left_x;
        logic [FIELD_W-1:0] left_y;
        logic [FIELD_W-1:0] right_x;
        logic [FIELD_W-1:0] right_y;
    } t_res;

    // configuration as seen by the tracking logic
    typedef struct packed {
        logic [GSQ_W-1:0]   gate_sq;
        logic [FIELD_W-1:0] min_disp;
        logic [FIELD_W-1:0] max_disp;
        logic [CNT_W-1:0]   miss_limit;
    } t_cfg;

    // absolute difference of two coordinates
    function automatic t_coord abs_diff(input t_coord a, input t_coord b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ rtl/sgnt_ifs.sv @@
// channel interfaces: request, result and configuration write
interface sgnt_req_if;
    logic              valid;
    logic              ready;
    sgnt_pkg::t_req    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sgnt_res_if;
    logic              valid;
    logic              ready;
    sgnt_pkg::t_res    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sgnt_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sgnt_pkg::CFG_IDX_W-1:0]     index;
    logic [sgnt_pkg::FIELD_W-1:0]       wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/stereo_gated_nearest_tracker.sv @@
// top level: request register, tracking core, configuration and result register
// Takes one request per clock. A request is captured in the input register and
// handled there: a detected point updates the nearest point of its
// side (two 16x16 squares and a 33-bit compare), a set-center request loads a
// center, and an end-of-frame request writes its result into the output
// register as it leaves the input register; o_res shows that register. Points
// and set-center requests keep flowing while a result waits; only an
// end-of-frame request waits in the input register while the previous result
// is still not taken. Configuration writes are always ready; a new gate radius
// takes effect once r_gate and then r_gate_sq have been registered.
module stereo_gated_nearest_tracker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sgnt_req_if.sink   i_req,
    sgnt_res_if.source o_res,
    sgnt_cfg_if.sink   i_cfg
);

    logic           r_in_valid;
    sgnt_pkg::t_req r_in;
    logic           r_out_valid;
    sgnt_pkg::t_res r_out;
    logic           advance;
    logic           core_res_valid;
    sgnt_pkg::t_res core_res;
    sgnt_pkg::t_cfg cfg;

    // configuration port
    assign i_cfg.ready = 1'b1;

    sgnt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_wdata (i_cfg.wdata),
        .o_cfg   (cfg)
    );

    // a held request proceeds unless it is an end of frame facing a full output that is not being taken
    assign advance = r_in_valid
        && ((r_in.func != sgnt_pkg::FUNC_EOF) || !r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
    end

    sgnt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_req       (r_in),
        .i_cfg       (cfg),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res_valid) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

@@ rtl/sgnt_cfg.sv @@
// configuration registers with the squared gate radius kept alongside
module sgnt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [sgnt_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [sgnt_pkg::FIELD_W-1:0]  i_wdata,
    output sgnt_pkg::t_cfg                o_cfg
);

    logic [sgnt_pkg::FIELD_W-1:0] r_gate;
    logic [sgnt_pkg::GSQ_W-1:0]   r_gate_sq;
    logic [sgnt_pkg::FIELD_W-1:0] r_min_disp;
    logic [sgnt_pkg::FIELD_W-1:0] r_max_disp;
    logic [sgnt_pkg::CNT_W-1:0]   r_limit;
    logic [sgnt_pkg::GSQ_W-1:0]   n_gate_sq;

    // square of the radius, registered in the cycle after the write
    assign n_gate_sq = sgnt_pkg::GSQ_W'(r_gate) * sgnt_pkg::GSQ_W'(r_gate);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate     <= sgnt_pkg::GATE_RST;
            r_gate_sq  <= sgnt_pkg::GATE_SQ_RST;
            r_min_disp <= sgnt_pkg::MIN_DISP_RST;
            r_max_disp <= sgnt_pkg::MAX_DISP_RST;
            r_limit    <= sgnt_pkg::LIMIT_RST;
        end else begin
            r_gate_sq <= n_gate_sq;
            if (i_wr) begin
                case (i_index)
                    sgnt_pkg::CFG_GATE:     r_gate     <= i_wdata;
                    sgnt_pkg::CFG_MIN_DISP: r_min_disp <= i_wdata;
                    sgnt_pkg::CFG_MAX_DISP: r_max_disp <= i_wdata;
                    sgnt_pkg::CFG_LIMIT:    r_limit    <= i_wdata[sgnt_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_cfg.gate_sq    = r_gate_sq;
    assign o_cfg.min_disp   = r_min_disp;
    assign o_cfg.max_disp   = r_max_disp;
    assign o_cfg.miss_limit = r_limit;

endmodule

@@ rtl/sgnt_core.sv @@
// tracking state: per-side nearest search, set center and end-of-frame evaluation
module sgnt_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  sgnt_pkg::t_req i_req,
    input  sgnt_pkg::t_cfg i_cfg,
    output logic           o_res_valid,
    output sgnt_pkg::t_res o_res
);

    sgnt_pkg::t_coord             r_cx [2];
    sgnt_pkg::t_coord             r_cy [2];
    sgnt_pkg::t_coord             r_bx [2];
    sgnt_pkg::t_coord             r_by [2];
    logic [sgnt_pkg::SQ_W-1:0]    r_bd [2];
    logic [1:0]                   r_have;
    logic                         r_lost;
    logic [sgnt_pkg::CNT_W-1:0]   r_cnt;

    sgnt_pkg::t_coord             n_cx [2];
    sgnt_pkg::t_coord             n_cy [2];
    sgnt_pkg::t_coord             n_bx [2];
    sgnt_pkg::t_coord             n_by [2];
    logic [sgnt_pkg::SQ_W-1:0]    n_bd [2];
    logic [1:0]                   n_have;
    logic                         n_lost;
    logic [sgnt_pkg::CNT_W-1:0]   n_cnt;

    logic                         s;
    sgnt_pkg::t_coord             px;
    sgnt_pkg::t_coord             py;
    sgnt_pkg::t_coord             dx;
    sgnt_pkg::t_coord             dy;
    logic [2*sgnt_pkg::COORD_W-1:0] sqx;
    logic [2*sgnt_pkg::COORD_W-1:0] sqy;
    logic [sgnt_pkg::SQ_W-1:0]    sq_dist;
    logic [1:0]                   matched;
    logic [sgnt_pkg::DISP_W-1:0]  disp;
    logic [sgnt_pkg::CNT_W-1:0]   cnt_inc;
    logic [1:0]                   status;

    // coordinates keep their low bits only
    assign s  = i_req.side;
    assign px = sgnt_pkg::COORD_W'(i_req.point_x);
    assign py = sgnt_pkg::COORD_W'(i_req.point_y);

    // squared distance to the center of the tagged side
    assign dx      = sgnt_pkg::abs_diff(px, r_cx[s]);
    assign dy      = sgnt_pkg::abs_diff(py, r_cy[s]);
    assign sqx     = dx * dx;
    assign sqy     = dy * dy;
    assign sq_dist = sgnt_pkg::SQ_W'(sqx) + sgnt_pkg::SQ_W'(sqy);

    // gate test per side; a best point at the origin never matches
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            matched[k] = r_have[k]
                && (sgnt_pkg::GCMP_W'(r_bd[k]) < sgnt_pkg::GCMP_W'(i_cfg.gate_sq))
                && !((r_bx[k] == '0) && (r_by[k] == '0));
        end
    end

    assign disp    = sgnt_pkg::DISP_W'(sgnt_pkg::abs_diff(r_bx[0], r_bx[1]));
    assign cnt_inc = r_cnt + sgnt_pkg::CNT_W'(1);

    // next state
    always_comb begin
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_bx   = r_bx;
        n_by   = r_by;
        n_bd   = r_bd;
        n_have = r_have;
        n_lost = r_lost;
        n_cnt  = r_cnt;
        status = sgnt_pkg::ST_ACCEPT;
        if (i_fire) begin
            case (i_req.func)
                sgnt_pkg::FUNC_POINT: begin
                    if (!r_have[s] || (sq_dist < r_bd[s])) begin
                        n_bd[s]   = sq_dist;
                        n_bx[s]   = px;
                        n_by[s]   = py;
                        n_have[s] = 1'b1;
                    end
                end
                sgnt_pkg::FUNC_SET: begin
                    n_cx[s] = px;
                    n_cy[s] = py;
                    n_lost  = 1'b0;
                end
                sgnt_pkg::FUNC_EOF: begin
                    if (!(matched[0] && matched[1])) begin
                        status = sgnt_pkg::ST_MISS;
                        if (cnt_inc >= i_cfg.miss_limit) begin
                            n_cnt  = '0;
                            n_lost = 1'b1;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end else if ((disp > sgnt_pkg::DISP_W'(i_cfg.min_disp))
                              && (disp < sgnt_pkg::DISP_W'(i_cfg.max_disp))) begin
                        status = sgnt_pkg::ST_ACCEPT;
                        n_cnt  = '0;
                        n_lost = 1'b0;
                        n_cx   = r_bx;
                        n_cy   = r_by;
                    end else begin
                        status = sgnt_pkg::ST_REJECT;
                    end
                    n_have = '0;
                end
                default: ;
            endcase
        end
    end

    // result of an end-of-frame request
    always_comb begin
        o_res_valid      = i_fire && (i_req.func == sgnt_pkg::FUNC_EOF);
        o_res.status     = status;
        o_res.is_lost    = n_lost;
        o_res.miss_count = n_cnt;
        o_res.left_x     = sgnt_pkg::FIELD_W'(n_cx[0]);
        o_res.left_y     = sgnt_pkg::FIELD_W'(n_cy[0]);
        o_res.right_x    = sgnt_pkg::FIELD_W'(n_cx[1]);
        o_res.right_y    = sgnt_pkg::FIELD_W'(n_cy[1]);
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '{default: '0};
            r_cy   <= '{default: '0};
            r_bx   <= '{default: '0};
            r_by   <= '{default: '0};
            r_bd   <= '{default: '0};
            r_have <= '0;
            r_lost <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_bx   <= n_bx;
            r_by   <= n_by;
            r_bd   <= n_bd;
            r_have <= n_have;
            r_lost <= n_lost;
            r_cnt  <= n_cnt;
        end
    end

endmodule

@@ rtl/sgnt_chk.sv @@
// port-level checks of the tracker, bound to the top level
module sgnt_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_res_valid,
    input logic           i_res_ready,
    input sgnt_pkg::t_res i_res_data,
    input logic           i_cfg_ready
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("result changed while stalled");

    // an accepted frame clears the miss counter and the lost mark
    a_accept_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_data.status == sgnt_pkg::ST_ACCEPT)
        |-> !i_res_data.is_lost && (i_res_data.miss_count == '0))
        else $error("accepted frame left miss state");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result after reset");

    // only the three status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_data.status == sgnt_pkg::ST_ACCEPT)
            || (i_res_data.status == sgnt_pkg::ST_MISS)
            || (i_res_data.status == sgnt_pkg::ST_REJECT))
        else $error("bad status code");

    // configuration writes never stall
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port stalled");

endmodule

bind stereo_gated_nearest_tracker sgnt_chk u_sgnt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data),
    .i_cfg_ready (i_cfg.ready)
);

@@ sim/tb_top.sv @@
// testbench of the stereo gated nearest tracker: random requests, predicted frame results
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_WAIT     = 12;
    localparam int RX_HOLD      = 200;
    localparam int SETTLE       = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sgnt_req_if req_if ();
    sgnt_res_if res_if ();
    sgnt_cfg_if cfg_if ();

    stereo_gated_nearest_tracker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // tracker state as predicted from the accepted requests
    sgnt_pkg::t_coord                 trk_center [4];
    sgnt_pkg::t_coord                 trk_best   [4];
    logic [sgnt_pkg::SQ_W-1:0]        trk_best_d [2];
    bit                               trk_have   [2];
    bit                               trk_lost;
    logic [sgnt_pkg::CNT_W-1:0]       trk_misses;
    logic [sgnt_pkg::FIELD_W-1:0]     reg_gate, reg_min_disp, reg_max_disp;
    logic [sgnt_pkg::CNT_W-1:0]       reg_limit;

    sgnt_pkg::t_req request_q [$];
    sgnt_pkg::t_res frame_results_q [$];

    int n_pushed, n_taken, n_items, n_errors, n_settings, n_lost_events;
    int n_frames, n_accept, n_miss, n_reject;
    int hold_reqs;

    function automatic void tracker_reset();
        for (int k = 0; k < 4; k++) begin
            trk_center[k] = '0;
            trk_best[k]   = '0;
        end
        trk_best_d[0] = '0;
        trk_best_d[1] = '0;
        trk_have[0]   = 1'b0;
        trk_have[1]   = 1'b0;
        trk_lost      = 1'b0;
        trk_misses    = '0;
        reg_gate      = sgnt_pkg::GATE_RST;
        reg_min_disp  = sgnt_pkg::MIN_DISP_RST;
        reg_max_disp  = sgnt_pkg::MAX_DISP_RST;
        reg_limit     = sgnt_pkg::LIMIT_RST;
    endfunction

    function automatic sgnt_pkg::t_coord coord_gap(input sgnt_pkg::t_coord a,
                                                   input sgnt_pkg::t_coord b);
        return (a >= b) ? sgnt_pkg::t_coord'(a - b) : sgnt_pkg::t_coord'(b - a);
    endfunction

    // a side matches when its nearest point is inside the gate and not the origin
    function automatic bit side_in_gate(input int s);
        logic [2*sgnt_pkg::FIELD_W-1:0] gate_sq;
        gate_sq = reg_gate * reg_gate;
        if (!trk_have[s])
            return 1'b0;
        if (trk_best_d[s] >= sgnt_pkg::SQ_W'(gate_sq))
            return 1'b0;
        if (trk_best[2*s] == '0 && trk_best[2*s+1] == '0)
            return 1'b0;
        return 1'b1;
    endfunction

    // advance the predicted state by one request, queue the frame result if any
    task automatic track_request(input sgnt_pkg::t_req r);
        sgnt_pkg::t_coord             px, py, dx, dy;
        logic [sgnt_pkg::SQ_W-1:0]    dsq;
        logic [sgnt_pkg::FIELD_W-1:0] disp;
        sgnt_pkg::t_res               res;
        int                           s;
        s  = r.side;
        px = sgnt_pkg::t_coord'(r.point_x);
        py = sgnt_pkg::t_coord'(r.point_y);
        case (r.func)
            sgnt_pkg::FUNC_POINT: begin
                dx  = coord_gap(px, trk_center[2*s]);
                dy  = coord_gap(py, trk_center[2*s+1]);
                dsq = sgnt_pkg::SQ_W'(dx) * sgnt_pkg::SQ_W'(dx)
                    + sgnt_pkg::SQ_W'(dy) * sgnt_pkg::SQ_W'(dy);
                if (!trk_have[s] || dsq < trk_best_d[s]) begin
                    trk_best_d[s]    = dsq;
                    trk_best[2*s]    = px;
                    trk_best[2*s+1]  = py;
                    trk_have[s]      = 1'b1;
                end
            end
            sgnt_pkg::FUNC_SET: begin
                trk_center[2*s]   = px;
                trk_center[2*s+1] = py;
                trk_lost          = 1'b0;
            end
            sgnt_pkg::FUNC_EOF: begin
                if (!side_in_gate(0) || !side_in_gate(1)) begin
                    res.status = sgnt_pkg::ST_MISS;
                    trk_misses = trk_misses + 1'b1;
                    if (trk_misses >= reg_limit) begin
                        trk_misses = '0;
                        trk_lost   = 1'b1;
                        n_lost_events++;
                    end
                end else begin
                    disp = coord_gap(trk_best[0], trk_best[2]);
                    if (disp > reg_min_disp && disp < reg_max_disp) begin
                        res.status = sgnt_pkg::ST_ACCEPT;
                        trk_misses = '0;
                        for (int k = 0; k < 4; k++)
                            trk_center[k] = trk_best[k];
                        trk_lost = 1'b0;
                    end else begin
                        res.status = sgnt_pkg::ST_REJECT;
                    end
                end
                trk_have[0]   = 1'b0;
                trk_have[1]   = 1'b0;
                trk_best_d[0] = '0;
                trk_best_d[1] = '0;
                res.is_lost    = trk_lost;
                res.miss_count = trk_misses;
                res.left_x     = trk_center[0];
                res.left_y     = trk_center[1];
                res.right_x    = trk_center[2];
                res.right_y    = trk_center[3];
                frame_results_q.insert(frame_results_q.size(), res);
            end
            default: ;
        endcase
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endfunction

    // request driver: random gaps between requests, calm stretches without gaps
    int tx_gap;
    bit tx_calm;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
            tx_gap  = 0;
            tx_calm = 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                track_request(req_if.data);
                n_taken++;
                if ($urandom_range(0, 47) == 0)
                    tx_calm = !tx_calm;
                tx_gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!req_if.valid || req_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    req_if.valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= request_q.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares against the oldest predicted frame result
    int rx_wait, rx_hold, holds_seen;
    bit rx_calm;
    sgnt_pkg::t_res want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_wait    = 0;
            rx_hold    = 0;
            holds_seen = 0;
            rx_calm    = 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                n_frames++;
                if (frame_results_q.size() == 0) begin
                    $error("frame result with none pending: status %0d", res_if.data.status);
                    n_errors++;
                end else begin
                    want = frame_results_q.pop_front();
                    check_field("status",     want.status,     res_if.data.status);
                    check_field("is_lost",    want.is_lost,    res_if.data.is_lost);
                    check_field("miss_count", want.miss_count, res_if.data.miss_count);
                    check_field("left_x",     want.left_x,     res_if.data.left_x);
                    check_field("left_y",     want.left_y,     res_if.data.left_y);
                    check_field("right_x",    want.right_x,    res_if.data.right_x);
                    check_field("right_y",    want.right_y,    res_if.data.right_y);
                    case (want.status)
                        sgnt_pkg::ST_ACCEPT: n_accept++;
                        sgnt_pkg::ST_MISS:   n_miss++;
                        default:             n_reject++;
                    endcase
                end
                if ($urandom_range(0, 31) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (holds_seen != hold_reqs) begin
                holds_seen = hold_reqs;
                rx_hold    = RX_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                res_if.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake
    int stall_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
                     || (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $error("no request, result or register write moved for %0d cycles",
                       stall_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic push_req(input logic [1:0] func, input logic side,
                            input logic [sgnt_pkg::FIELD_W-1:0] px,
                            input logic [sgnt_pkg::FIELD_W-1:0] py);
        sgnt_pkg::t_req r;
        r.func    = func;
        r.side    = side;
        r.point_x = px;
        r.point_y = py;
        request_q.insert(request_q.size(), r);
        n_pushed++;
        if (func != FUNC_UNUSED)
            n_items++;
    endtask

    // register write on the configuration channel
    task automatic write_reg(input logic [sgnt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sgnt_pkg::FIELD_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= val;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            sgnt_pkg::CFG_GATE:     reg_gate     = val;
            sgnt_pkg::CFG_MIN_DISP: reg_min_disp = val;
            sgnt_pkg::CFG_MAX_DISP: reg_max_disp = val;
            sgnt_pkg::CFG_LIMIT:    reg_limit    = val[sgnt_pkg::CNT_W-1:0];
            default: ;
        endcase
    endtask

    // all requests taken, all results seen, then a settling wait for points in flight
    task automatic wait_idle();
        do @(negedge i_clk);
        while (n_pushed != n_taken || frame_results_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [sgnt_pkg::FIELD_W-1:0] gate,
                              input logic [sgnt_pkg::FIELD_W-1:0] mn,
                              input logic [sgnt_pkg::FIELD_W-1:0] mx,
                              input logic [sgnt_pkg::CNT_W-1:0] lim);
        wait_idle();
        write_reg(sgnt_pkg::CFG_GATE, gate);
        write_reg(sgnt_pkg::CFG_MIN_DISP, mn);
        write_reg(sgnt_pkg::CFG_MAX_DISP, mx);
        write_reg(sgnt_pkg::CFG_LIMIT, sgnt_pkg::FIELD_W'(lim));
        n_settings++;
        repeat (4) @(negedge i_clk);
    endtask

    // one frame: maybe new centers, points mostly near the current centers, end of frame
    task automatic random_frame(input int max_pts);
        int               n_left, n_right, spread, d, pick;
        sgnt_pkg::t_coord lx, ly, px, py;
        logic             s;
        if ($urandom_range(0, 7) == 0) begin
            lx = sgnt_pkg::t_coord'($urandom_range(0, 16'hFFFF));
            ly = sgnt_pkg::t_coord'($urandom_range(0, 16'hFFFF));
            if (int'(reg_max_disp) > int'(reg_min_disp) + 1)
                d = $urandom_range(int'(reg_min_disp) + 1, int'(reg_max_disp) - 1);
            else
                d = $urandom_range(0, 16'hFFFF);
            push_req(sgnt_pkg::FUNC_SET, 1'b0, lx, ly);
            push_req(sgnt_pkg::FUNC_SET, 1'b1,
                     (int'(lx) >= d) ? sgnt_pkg::t_coord'(int'(lx) - d)
                                     : sgnt_pkg::t_coord'(lx + d),
                     sgnt_pkg::t_coord'(ly + $urandom_range(0, 64)));
        end
        spread  = ($urandom_range(0, 3) == 0) ? 4000 : ((reg_gate < 16) ? 16 : int'(reg_gate));
        n_left  = $urandom_range(0, max_pts);
        n_right = $urandom_range(0, max_pts);
        while (n_left + n_right > 0) begin
            if (n_right == 0 || (n_left > 0 && $urandom_range(0, 1) == 0)) begin
                s = 1'b0;
                n_left--;
            end else begin
                s = 1'b1;
                n_right--;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                px = '0;
                py = '0;
            end else if (pick < 4) begin
                px = sgnt_pkg::t_coord'($urandom_range(0, 16'hFFFF));
                py = sgnt_pkg::t_coord'($urandom_range(0, 16'hFFFF));
            end else begin
                px = sgnt_pkg::t_coord'(int'(trk_center[2*s])
                                        + $urandom_range(0, 2 * spread) - spread);
                py = sgnt_pkg::t_coord'(int'(trk_center[2*s+1])
                                        + $urandom_range(0, 2 * spread) - spread);
            end
            push_req(sgnt_pkg::FUNC_POINT, s, px, py);
            // noise and a rare mid-frame center load
            if ($urandom_range(0, 29) == 0)
                push_req(FUNC_UNUSED, 1'($urandom), 16'($urandom), 16'($urandom));
            if ($urandom_range(0, 39) == 0)
                push_req(sgnt_pkg::FUNC_SET, 1'($urandom), 16'($urandom), 16'($urandom));
        end
        push_req(sgnt_pkg::FUNC_EOF, 1'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // frames are built against the current predicted centers, so each waits for the last
    task automatic run_random(input int n_target, input int max_pts);
        int start;
        start = n_items;
        while (n_items - start < n_target) begin
            do @(negedge i_clk);
            while (n_pushed != n_taken);
            random_frame(max_pts);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.wdata = '0;
        tracker_reset();
        n_settings = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // frame with no points at all
        push_req(sgnt_pkg::FUNC_EOF, 1'b0, 16'd0, 16'd0);
        // centers, nearest point wins, farther in-gate point ignored
        push_req(sgnt_pkg::FUNC_SET, 1'b0, 16'd5000, 16'd3000);
        push_req(sgnt_pkg::FUNC_SET, 1'b1, 16'd2000, 16'd3000);
        push_req(sgnt_pkg::FUNC_POINT, 1'b0, 16'd5100, 16'd3000);
        push_req(sgnt_pkg::FUNC_POINT, 1'b0, 16'd5000, 16'd3000);
        push_req(sgnt_pkg::FUNC_POINT, 1'b1, 16'd1990, 16'd3010);
        push_req(sgnt_pkg::FUNC_POINT, 1'b1, 16'd2479, 16'd3000);
        push_req(sgnt_pkg::FUNC_EOF, 1'b1, 16'hFFFF, 16'hFFFF);
        // point exactly on the gate radius does not match
        push_req(sgnt_pkg::FUNC_POINT, 1'b0, 16'd5480, 16'd3000);
        push_req(sgnt_pkg::FUNC_POINT, 1'b1, 16'd1990, 16'd3010);
        push_req(sgnt_pkg::FUNC_EOF, 1'b0, 16'd0, 16'd0);
        // equal distances: first point kept
        push_req(sgnt_pkg::FUNC_POINT, 1'b0, 16'd5100, 16'd3000);
        push_req(sgnt_pkg::FUNC_POINT, 1'b0, 16'd4900, 16'd3000);
        push_req(sgnt_pkg::FUNC_POINT, 1'b1, 16'd1990, 16'd3110);
        push_req(sgnt_pkg::FUNC_EOF, 1'b0, 16'd0, 16'd0);
        // disparity equal to the minimum is rejected
        push_req(sgnt_pkg::FUNC_SET, 1'b0, 16'd3590, 16'd3000);
        push_req(sgnt_pkg::FUNC_POINT, 1'b0, 16'd3590, 16'd3000);
        push_req(sgnt_pkg::FUNC_POINT, 1'b1, 16'd1990, 16'd3110);
        push_req(sgnt_pkg::FUNC_EOF, 1'b0, 16'd0, 16'd0);
        // best point at the origin counts as no match
        push_req(sgnt_pkg::FUNC_SET, 1'b1, 16'd0, 16'd0);
        push_req(sgnt_pkg::FUNC_POINT, 1'b1, 16'd0, 16'd0);
        push_req(sgnt_pkg::FUNC_POINT, 1'b0, 16'd3590, 16'd3000);
        push_req(sgnt_pkg::FUNC_EOF, 1'b1, 16'd0, 16'd0);
        // top of the coordinate range, disparity equal to the maximum
        push_req(sgnt_pkg::FUNC_SET, 1'b0, 16'hFFFF, 16'hFFFF);
        push_req(sgnt_pkg::FUNC_POINT, 1'b0, 16'hFFFF, 16'hFFFF);
        push_req(sgnt_pkg::FUNC_SET, 1'b1, 16'd51135, 16'hFFFF);
        push_req(sgnt_pkg::FUNC_POINT, 1'b1, 16'd51135, 16'hFFFF);
        push_req(sgnt_pkg::FUNC_EOF, 1'b0, 16'd0, 16'd0);
        // unused function code is dropped
        push_req(FUNC_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF);

        // back-pressure: sink holds off while several frames are offered
        wait_idle();
        hold_reqs++;
        push_req(sgnt_pkg::FUNC_EOF, 1'b0, 16'd0, 16'd0);
        push_req(sgnt_pkg::FUNC_POINT, 1'b0, 16'hFFF0, 16'hFFF0);
        push_req(sgnt_pkg::FUNC_EOF, 1'b1, 16'd0, 16'd0);
        push_req(sgnt_pkg::FUNC_SET, 1'b0, 16'd5000, 16'd3000);
        push_req(sgnt_pkg::FUNC_SET, 1'b1, 16'd2000, 16'd3000);
        push_req(sgnt_pkg::FUNC_POINT, 1'b1, 16'd2010, 16'd3000);
        push_req(sgnt_pkg::FUNC_POINT, 1'b0, 16'd5010, 16'd3000);
        push_req(sgnt_pkg::FUNC_EOF, 1'b0, 16'd0, 16'd0);
        push_req(sgnt_pkg::FUNC_EOF, 1'b1, 16'd0, 16'd0);

        run_random(300, 4);
        // widest gate and disparity window
        set_config(16'hFFFF, 16'd0, 16'hFFFF, 8'd255);
        run_random(250, 4);
        // nothing can match, long miss run up to the largest limit
        set_config(16'd0, 16'hFFFF, 16'd0, 8'd255);
        run_random(300, 1);
        // miss limit of zero: lost on every miss
        set_config(16'd600, 16'd1000, 16'd20000, 8'd0);
        run_random(200, 3);
        set_config(16'($urandom_range(100, 4000)), 16'($urandom_range(0, 8000)),
                   16'($urandom_range(12000, 40000)), 8'($urandom_range(1, 8)));
        run_random(250, 4);
        set_config(16'($urandom), 16'($urandom), 16'($urandom), 8'd1);
        run_random(250, 3);

        wait_idle();
        $display("tracker run: %0d requests under %0d register settings, %0d frame results",
                 n_taken, n_settings, n_frames);
        $display("  %0d accepted, %0d missing a side, %0d rejected, %0d lost events",
                 n_accept, n_miss, n_reject, n_lost_events);
        if (n_errors == 0 && frame_results_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
